[hdl/sssd_pkg.sv]
// Shared types, constants and code tables of the seven-segment scan driver.
package sssd_pkg;

    localparam int DIGIT_COUNT      = 8;
    localparam int TICKS_PER_SECOND = 1000;
    localparam int POS_W            = $clog2(DIGIT_COUNT);
    localparam int MS_W             = $clog2(TICKS_PER_SECOND);
    localparam int SEC_W            = 6;
    localparam int HALF_DIGITS      = 4;
    localparam int NUM_W            = 14;
    localparam int QUO_W            = 19;
    localparam int PAIR_W           = 7;
    localparam int DIG_W            = 4;

    localparam logic [MS_W-1:0]  MS_LAST     = MS_W'(TICKS_PER_SECOND - 1);
    localparam logic [SEC_W-1:0] LAST_SECOND = 6'd59;
    localparam logic [7:0]       DASH_CODE   = 8'hfd;
    localparam logic [NUM_W-1:0] HALF_LIMIT  = 14'd10000;

    // Reciprocals: value / 10000, value / 100 and value / 10 by multiply and shift.
    localparam logic [31:0] RECIP_10K = 32'hd1b71759;
    localparam logic [13:0] RECIP_100 = 14'd10486;
    localparam logic [7:0]  RECIP_10  = 8'd205;

    localparam logic [9:0][7:0] FONT_CODES = {
        8'h09, 8'h01, 8'h1f, 8'h41, 8'h49, 8'h99, 8'h0d, 8'h25, 8'h9f, 8'h03
    };

    localparam logic [DIGIT_COUNT-1:0][15:0] SELECT_BITS = {
        16'h1000, 16'h2000, 16'h4000, 16'h8000,
        16'h0100, 16'h0200, 16'h0400, 16'h0800
    };

    typedef enum logic [1:0] {
        CMD_TICK       = 2'd0,
        CMD_LOAD_LEFT  = 2'd1,
        CMD_LOAD_RIGHT = 2'd2,
        CMD_LOAD_ALL   = 2'd3
    } command_t;

    localparam int LEFT  = 0;
    localparam int RIGHT = 1;

    typedef struct packed {
        logic             wr;
        logic             dash;
        logic [NUM_W-1:0] num;
    } half_num_t;

    typedef struct packed {
        command_t        cmd;
        half_num_t [1:0] half;
    } split_t;

    // pair[1] holds the upper two digits of a half, pair[0] the lower two.
    typedef struct packed {
        logic                   wr;
        logic                   dash;
        logic [1:0][PAIR_W-1:0] pair;
        logic [1:0][DIG_W-1:0]  tens;
    } half_dig_t;

    typedef struct packed {
        command_t        cmd;
        half_dig_t [1:0] half;
    } digit_t;

endpackage

[hdl/sssd_req_if.sv]
// Request channel: command and value with valid/ready handshake.
interface sssd_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  command;
    logic [31:0] value;

    modport source (output valid, output command, output value, input ready);
    modport sink   (input valid, input command, input value, output ready);
endinterface

[hdl/sssd_res_if.sv]
// Result channel: shift word, digit index and seconds with valid/ready handshake.
interface sssd_res_if;
    logic        valid;
    logic        ready;
    logic [15:0] shift_word;
    logic [2:0]  digit_index;
    logic [5:0]  seconds;

    modport source (output valid, output shift_word, output digit_index, output seconds,
                    input ready);
    modport sink   (input valid, input shift_word, input digit_index, input seconds,
                    output ready);
endinterface

[hdl/seven_segment_scan_driver.sv]
// Top level of the eight-digit multiplexed seven-segment scan driver.
// Accepts and sustains one request per clock while results are taken; a tick held by a
// waiting result stalls the stages behind it. Each request passes through six pipeline
// registers: the request register, a 32x32 reciprocal multiply for the division by 10000,
// the half selection, a reciprocal multiply by 1/100, the remainder of the pair split, and
// the tens of each pair; the last stage updates the segment store and the counters. A tick
// returns its result from an output register; a load returns nothing and affects every
// tick accepted after it. Requests keep flowing into empty stages while a result waits.
module seven_segment_scan_driver (
    input  logic       clk,
    input  logic       rst_n,
    sssd_req_if.sink   req,
    sssd_res_if.source res
);

    logic             split_valid;
    logic             split_ready;
    sssd_pkg::split_t split_data;
    logic             digit_valid;
    logic             digit_ready;
    sssd_pkg::digit_t digit_data;

    sssd_split u_split (
        .clk         (clk),
        .rst_n       (rst_n),
        .req         (req),
        .split_valid (split_valid),
        .split_data  (split_data),
        .split_ready (split_ready)
    );

    sssd_digits u_digits (
        .clk         (clk),
        .rst_n       (rst_n),
        .split_valid (split_valid),
        .split_data  (split_data),
        .split_ready (split_ready),
        .digit_valid (digit_valid),
        .digit_data  (digit_data),
        .digit_ready (digit_ready)
    );

    sssd_scan u_scan (
        .clk         (clk),
        .rst_n       (rst_n),
        .digit_valid (digit_valid),
        .digit_data  (digit_data),
        .digit_ready (digit_ready),
        .res         (res)
    );

endmodule

[hdl/sssd_split.sv]
// Request register, division by 10000 and selection of the number for each half.
module sssd_split (
    input  logic             clk,
    input  logic             rst_n,
    sssd_req_if.sink         req,
    output logic             split_valid,
    output sssd_pkg::split_t split_data,
    input  logic             split_ready
);

    logic                           v1_reg;
    sssd_pkg::command_t             cmd1_reg;
    logic [31:0]                    val1_reg;
    logic                           v2_reg;
    sssd_pkg::command_t             cmd2_reg;
    logic [31:0]                    val2_reg;
    logic [sssd_pkg::QUO_W-1:0]     quo2_reg;
    logic                           v3_reg;
    sssd_pkg::split_t               s3_reg;
    sssd_pkg::split_t               s3_next;
    logic                           rdy1;
    logic                           rdy2;
    logic                           rdy3;
    logic [63:0]                    prod;
    logic [32:0]                    quo_scaled;
    logic [sssd_pkg::NUM_W-1:0]     rem;

    assign rdy3      = !v3_reg || split_ready;
    assign rdy2      = !v2_reg || rdy3;
    assign rdy1      = !v1_reg || rdy2;
    assign req.ready = rdy1;

    assign prod       = 64'(val1_reg) * 64'(sssd_pkg::RECIP_10K);
    assign quo_scaled = 33'(quo2_reg) * 33'(sssd_pkg::HALF_LIMIT);
    assign rem        = sssd_pkg::NUM_W'(val2_reg - quo_scaled[31:0]);

    always_comb
    begin
        s3_next.cmd = cmd2_reg;
        s3_next.half[sssd_pkg::LEFT]  = '0;
        s3_next.half[sssd_pkg::RIGHT] = '0;
        unique case (cmd2_reg)
            sssd_pkg::CMD_LOAD_LEFT:
            begin
                s3_next.half[sssd_pkg::LEFT].wr   = 1'b1;
                s3_next.half[sssd_pkg::LEFT].dash = val2_reg >= 32'(sssd_pkg::HALF_LIMIT);
                s3_next.half[sssd_pkg::LEFT].num  = val2_reg[sssd_pkg::NUM_W-1:0];
            end
            sssd_pkg::CMD_LOAD_RIGHT:
            begin
                s3_next.half[sssd_pkg::RIGHT].wr   = 1'b1;
                s3_next.half[sssd_pkg::RIGHT].dash = val2_reg >= 32'(sssd_pkg::HALF_LIMIT);
                s3_next.half[sssd_pkg::RIGHT].num  = val2_reg[sssd_pkg::NUM_W-1:0];
            end
            sssd_pkg::CMD_LOAD_ALL:
            begin
                s3_next.half[sssd_pkg::LEFT].wr   = 1'b1;
                s3_next.half[sssd_pkg::LEFT].dash =
                    quo2_reg >= sssd_pkg::QUO_W'(sssd_pkg::HALF_LIMIT);
                s3_next.half[sssd_pkg::LEFT].num  = quo2_reg[sssd_pkg::NUM_W-1:0];
                s3_next.half[sssd_pkg::RIGHT].wr  = 1'b1;
                s3_next.half[sssd_pkg::RIGHT].num = rem;
            end
            sssd_pkg::CMD_TICK:
            begin
                s3_next.half[sssd_pkg::LEFT].wr = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (rdy1)
                v1_reg <= req.valid;
            if (rdy2)
                v2_reg <= v1_reg;
            if (rdy3)
                v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy1 && req.valid)
        begin
            cmd1_reg <= sssd_pkg::command_t'(req.command);
            val1_reg <= req.value;
        end
        if (rdy2 && v1_reg)
        begin
            cmd2_reg <= cmd1_reg;
            val2_reg <= val1_reg;
            quo2_reg <= prod[63:45];
        end
        if (rdy3 && v2_reg)
            s3_reg <= s3_next;
    end

    assign split_valid = v3_reg;
    assign split_data  = s3_reg;

endmodule

[hdl/sssd_digits.sv]
// Decimal split of each four-digit half into two pairs and the tens of each pair.
module sssd_digits (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             split_valid,
    input  sssd_pkg::split_t split_data,
    output logic             split_ready,
    output logic             digit_valid,
    output sssd_pkg::digit_t digit_data,
    input  logic             digit_ready
);

    typedef struct packed {
        logic                        wr;
        logic                        dash;
        logic [sssd_pkg::NUM_W-1:0]  num;
        logic [sssd_pkg::PAIR_W-1:0] hi;
    } h4_t;

    typedef struct packed {
        logic                             wr;
        logic                             dash;
        logic [1:0][sssd_pkg::PAIR_W-1:0] pair;
    } h5_t;

    logic                   v4_reg;
    sssd_pkg::command_t     cmd4_reg;
    h4_t [1:0]              h4_reg;
    h4_t [1:0]              h4_next;
    logic                   v5_reg;
    sssd_pkg::command_t     cmd5_reg;
    h5_t [1:0]              h5_reg;
    h5_t [1:0]              h5_next;
    logic                   v6_reg;
    sssd_pkg::digit_t       s6_reg;
    sssd_pkg::digit_t       s6_next;
    logic                   rdy4;
    logic                   rdy5;
    logic                   rdy6;
    logic [1:0][27:0]       hi_prod;
    logic [1:0][1:0][14:0]  tens_prod;

    assign rdy6        = !v6_reg || digit_ready;
    assign rdy5        = !v5_reg || rdy6;
    assign rdy4        = !v4_reg || rdy5;
    assign split_ready = rdy4;

    always_comb
    begin
        for (int h = 0; h < 2; h++)
        begin
            hi_prod[h]      = 28'(split_data.half[h].num) * 28'(sssd_pkg::RECIP_100);
            h4_next[h].wr   = split_data.half[h].wr;
            h4_next[h].dash = split_data.half[h].dash;
            h4_next[h].num  = split_data.half[h].num;
            h4_next[h].hi   = hi_prod[h][26:20];
        end
    end

    always_comb
    begin
        for (int h = 0; h < 2; h++)
        begin
            h5_next[h].wr      = h4_reg[h].wr;
            h5_next[h].dash    = h4_reg[h].dash;
            h5_next[h].pair[1] = h4_reg[h].hi;
            h5_next[h].pair[0] = sssd_pkg::PAIR_W'(h4_reg[h].num
                - sssd_pkg::NUM_W'(h4_reg[h].hi) * sssd_pkg::NUM_W'(100));
        end
    end

    always_comb
    begin
        s6_next.cmd = cmd5_reg;
        for (int h = 0; h < 2; h++)
        begin
            s6_next.half[h].wr   = h5_reg[h].wr;
            s6_next.half[h].dash = h5_reg[h].dash;
            for (int p = 0; p < 2; p++)
            begin
                tens_prod[h][p] = 15'(h5_reg[h].pair[p]) * 15'(sssd_pkg::RECIP_10);
                s6_next.half[h].pair[p] = h5_reg[h].pair[p];
                s6_next.half[h].tens[p] = tens_prod[h][p][14:11];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
        end
        else
        begin
            if (rdy4)
                v4_reg <= split_valid;
            if (rdy5)
                v5_reg <= v4_reg;
            if (rdy6)
                v6_reg <= v5_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy4 && split_valid)
        begin
            cmd4_reg <= split_data.cmd;
            h4_reg   <= h4_next;
        end
        if (rdy5 && v4_reg)
        begin
            cmd5_reg <= cmd4_reg;
            h5_reg   <= h5_next;
        end
        if (rdy6 && v5_reg)
            s6_reg <= s6_next;
    end

    assign digit_valid = v6_reg;
    assign digit_data  = s6_reg;

endmodule

[hdl/sssd_scan.sv]
// Segment store, millisecond, seconds and scan counters, and the result register.
module sssd_scan (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             digit_valid,
    input  sssd_pkg::digit_t digit_data,
    output logic             digit_ready,
    sssd_res_if.source       res
);

    logic [7:0]                 seg_reg  [sssd_pkg::DIGIT_COUNT];
    logic [7:0]                 seg_next [sssd_pkg::DIGIT_COUNT];
    logic [sssd_pkg::POS_W-1:0] scan_reg;
    logic [sssd_pkg::POS_W-1:0] scan_next;
    logic [sssd_pkg::MS_W-1:0]  ms_reg;
    logic [sssd_pkg::MS_W-1:0]  ms_next;
    logic [sssd_pkg::SEC_W-1:0] sec_reg;
    logic [sssd_pkg::SEC_W-1:0] sec_next;
    logic                       out_valid_reg;
    logic [15:0]                word_reg;
    logic [15:0]                word_next;
    logic [2:0]                 index_reg;
    logic [5:0]                 seconds_reg;
    logic                       is_tick;
    logic                       fire;
    logic                       fire_tick;
    logic                       fire_load;
    logic [3:0][sssd_pkg::DIG_W-1:0] dig;

    assign is_tick     = digit_data.cmd == sssd_pkg::CMD_TICK;
    assign digit_ready = !is_tick || !out_valid_reg || res.ready;
    assign fire        = digit_valid && digit_ready;
    assign fire_tick   = fire && is_tick;
    assign fire_load   = fire && !is_tick;

    always_comb
    begin
        for (int i = 0; i < sssd_pkg::DIGIT_COUNT; i++)
            seg_next[i] = seg_reg[i];
        dig = '0;
        for (int h = 0; h < 2; h++)
        begin
            dig[0] = digit_data.half[h].tens[1];
            dig[1] = sssd_pkg::DIG_W'(digit_data.half[h].pair[1]
                - sssd_pkg::PAIR_W'(digit_data.half[h].tens[1]) * sssd_pkg::PAIR_W'(10));
            dig[2] = digit_data.half[h].tens[0];
            dig[3] = sssd_pkg::DIG_W'(digit_data.half[h].pair[0]
                - sssd_pkg::PAIR_W'(digit_data.half[h].tens[0]) * sssd_pkg::PAIR_W'(10));
            if (fire_load && digit_data.half[h].wr)
            begin
                for (int k = 0; k < sssd_pkg::HALF_DIGITS; k++)
                begin
                    if (digit_data.half[h].dash)
                        seg_next[h * sssd_pkg::HALF_DIGITS + k] = sssd_pkg::DASH_CODE;
                    else
                        seg_next[h * sssd_pkg::HALF_DIGITS + k] = sssd_pkg::FONT_CODES[dig[k]];
                end
            end
        end
    end

    always_comb
    begin
        if (ms_reg == sssd_pkg::MS_LAST)
        begin
            ms_next = '0;
            if (sec_reg == sssd_pkg::LAST_SECOND)
                sec_next = '0;
            else
                sec_next = sec_reg + 1'b1;
        end
        else
        begin
            ms_next  = ms_reg + 1'b1;
            sec_next = sec_reg;
        end
        if (scan_reg == sssd_pkg::POS_W'(sssd_pkg::DIGIT_COUNT - 1))
            scan_next = '0;
        else
            scan_next = scan_reg + 1'b1;
        word_next = sssd_pkg::SELECT_BITS[scan_next] | {8'h00, seg_reg[scan_next]};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < sssd_pkg::DIGIT_COUNT; i++)
                seg_reg[i] <= sssd_pkg::FONT_CODES[i];
            scan_reg      <= '0;
            ms_reg        <= '0;
            sec_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            for (int i = 0; i < sssd_pkg::DIGIT_COUNT; i++)
                seg_reg[i] <= seg_next[i];
            if (fire_tick)
            begin
                scan_reg      <= scan_next;
                ms_reg        <= ms_next;
                sec_reg       <= sec_next;
                out_valid_reg <= 1'b1;
            end
            else if (res.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire_tick)
        begin
            word_reg    <= word_next;
            index_reg   <= 3'(scan_next);
            seconds_reg <= sec_next;
        end
    end

    assign res.valid       = out_valid_reg;
    assign res.shift_word  = word_reg;
    assign res.digit_index = index_reg;
    assign res.seconds     = seconds_reg;

    a_sec_wrap: assert property (@(posedge clk) disable iff (!rst_n)
        fire_tick && ms_reg == sssd_pkg::MS_LAST && sec_reg == sssd_pkg::LAST_SECOND
        |=> sec_reg == '0 && res.seconds == '0)
        else $error("seconds did not wrap after the last second");

    a_index_match: assert property (@(posedge clk) disable iff (!rst_n)
        fire_tick |=> res.valid && res.digit_index == 3'(scan_reg))
        else $error("result index differs from scan position");

    a_load_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        fire_load |=> $stable(ms_reg) && $stable(scan_reg) && $stable(sec_reg))
        else $error("load request changed a counter");

    a_ms_range: assert property (@(posedge clk) disable iff (!rst_n)
        ms_reg <= sssd_pkg::MS_LAST)
        else $error("millisecond count out of range");

endmodule

[sim/sssd_checker.sv]
// Watches both channels, predicts each scan word and compares it with the block's output.
`timescale 1ns / 1ps

module sssd_checker (
    input  logic clk,
    input  logic rst_n,
    sssd_req_if  req,
    sssd_res_if  res,
    output int   mismatches,
    output int   words_pending,
    output int   words_checked
);

    localparam int unsigned HALF_RANGE = 10000;
    localparam logic [7:0]  DASH       = 8'hfd;
    localparam logic [5:0]  SEC_WRAP   = 6'd59;

    typedef struct packed {
        logic [15:0] word;
        logic [2:0]  pos;
        logic [5:0]  sec;
    } scan_word_t;

    logic [7:0]  segments [8];
    logic [2:0]  scan_pos;
    int unsigned ms_count;
    logic [5:0]  sec_count;
    scan_word_t  scan_words [$];
    int          fail_count;
    int          pass_count;

    function automatic logic [7:0] glyph(input int unsigned d);
        case (d)
            0: return 8'h03;
            1: return 8'h9f;
            2: return 8'h25;
            3: return 8'h0d;
            4: return 8'h99;
            5: return 8'h49;
            6: return 8'h41;
            7: return 8'h1f;
            8: return 8'h01;
            default: return 8'h09;
        endcase
    endfunction

    function automatic logic [15:0] select_mask(input logic [2:0] pos);
        case (pos)
            3'd0: return 16'h0800;
            3'd1: return 16'h0400;
            3'd2: return 16'h0200;
            3'd3: return 16'h0100;
            3'd4: return 16'h8000;
            3'd5: return 16'h4000;
            3'd6: return 16'h2000;
            default: return 16'h1000;
        endcase
    endfunction

    task automatic store_half(input int base, input int unsigned num);
        if (num >= HALF_RANGE)
        begin
            for (int i = 0; i < 4; i++)
                segments[base + i] = DASH;
        end
        else
        begin
            segments[base]     = glyph((num / 1000) % 10);
            segments[base + 1] = glyph((num / 100) % 10);
            segments[base + 2] = glyph((num / 10) % 10);
            segments[base + 3] = glyph(num % 10);
        end
    endtask

    task automatic apply_request(input logic [1:0] cmd, input logic [31:0] num);
        scan_word_t next_word;
        case (sssd_pkg::command_t'(cmd))
            sssd_pkg::CMD_LOAD_LEFT:  store_half(0, num);
            sssd_pkg::CMD_LOAD_RIGHT: store_half(4, num);
            sssd_pkg::CMD_LOAD_ALL:
            begin
                store_half(0, num / HALF_RANGE);
                store_half(4, num % HALF_RANGE);
            end
            default:
            begin
                if (ms_count < sssd_pkg::TICKS_PER_SECOND - 1)
                    ms_count++;
                else
                begin
                    ms_count = 0;
                    sec_count = (sec_count == SEC_WRAP) ? 6'd0 : sec_count + 6'd1;
                end
                scan_pos = (scan_pos == 3'(sssd_pkg::DIGIT_COUNT - 1)) ? 3'd0
                                                                        : scan_pos + 3'd1;
                next_word.word = select_mask(scan_pos) | {8'h00, segments[scan_pos]};
                next_word.pos  = scan_pos;
                next_word.sec  = sec_count;
                scan_words.push_back(next_word);
            end
        endcase
    endtask

    task automatic flag_mismatch(input string what, input scan_word_t want,
                                 input scan_word_t got);
        fail_count++;
        if (fail_count <= 10)
            $display("%0t: %s: expected word %h digit %0d sec %0d, got word %h digit %0d sec %0d",
                     $realtime, what, want.word, want.pos, want.sec, got.word, got.pos, got.sec);
    endtask

    task automatic check_word();
        scan_word_t got;
        scan_word_t want;
        got.word = res.shift_word;
        got.pos  = res.digit_index;
        got.sec  = res.seconds;
        if (scan_words.size() == 0)
            flag_mismatch("scan word with nothing pending", '0, got);
        else
        begin
            want = scan_words.pop_front();
            if (got.word !== want.word || got.pos !== want.pos || got.sec !== want.sec)
                flag_mismatch("scan word mismatch", want, got);
            else
                pass_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 8; i++)
                segments[i] = glyph(i);
            scan_pos   = '0;
            ms_count   = 0;
            sec_count  = '0;
            fail_count = 0;
            pass_count = 0;
            scan_words.delete();
        end
        else
        begin
            if (res.valid && res.ready)
                check_word();
            if (req.valid && req.ready)
                apply_request(req.command, req.value);
        end
        mismatches    <= fail_count;
        words_pending <= scan_words.size();
        words_checked <= pass_count;
    end

endmodule

[sim/tb.sv]
// Stimulus, reset, clock and verdict for the seven-segment scan driver.
`timescale 1ns / 1ps

module tb;

    localparam int PHASE_ITEMS = 400;
    localparam int HOLD_CYCLES = 80;

    logic clk;
    logic rst_n;
    int   idle_pct;
    int   stall_pct;
    logic holding;
    logic hold_phase;
    logic hold_done;
    int   ticks_sent;
    int   loads_sent;
    int   mismatches;
    int   words_pending;
    int   words_checked;
    int   wait_cycles;

    sssd_req_if req ();
    sssd_res_if res ();

    seven_segment_scan_driver dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .res   (res)
    );

    sssd_checker word_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .req           (req),
        .res           (res),
        .mismatches    (mismatches),
        .words_pending (words_pending),
        .words_checked (words_checked)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #60_000_000;
        $display("end of test: mismatches");
        $finish;
    end

    always @(posedge clk)
        res.ready <= !holding && ($urandom_range(99) >= stall_pct);

    initial
    begin
        holding   <= 1'b0;
        hold_done = 1'b0;
        wait (hold_phase);
        repeat (3) @(posedge clk);
        holding <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        holding   <= 1'b0;
        hold_done = 1'b1;
    end

    task automatic send_request(input sssd_pkg::command_t cmd, input logic [31:0] num);
        while ($urandom_range(99) < idle_pct)
        begin
            req.valid <= 1'b0;
            @(posedge clk);
        end
        req.valid   <= 1'b1;
        req.command <= cmd;
        req.value   <= num;
        @(posedge clk);
        while (!req.ready)
            @(posedge clk);
        if (cmd == sssd_pkg::CMD_TICK)
            ticks_sent++;
        else
            loads_sent++;
    endtask

    task automatic drain();
        req.valid <= 1'b0;
        do
            @(posedge clk);
        while (words_pending != 0);
    endtask

    function automatic logic [31:0] pick_number();
        case ($urandom_range(4))
            0: return $urandom;
            1: return $urandom_range(9999);
            2: return $urandom_range(99_999_999);
            3: return 32'd9990 + $urandom_range(20);
            default: return 32'd99_999_990 + $urandom_range(20);
        endcase
    endfunction

    initial
    begin
        req.valid   <= 1'b0;
        req.command <= sssd_pkg::CMD_TICK;
        req.value   <= '0;
        rst_n       <= 1'b0;
        idle_pct   = 0;
        stall_pct  = 0;
        hold_phase = 1'b0;
        ticks_sent = 0;
        loads_sent = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_request(sssd_pkg::CMD_LOAD_ALL, 32'd12_345_678);
        repeat (8) send_request(sssd_pkg::CMD_TICK, $urandom);
        send_request(sssd_pkg::CMD_LOAD_LEFT, 32'd10000);
        send_request(sssd_pkg::CMD_LOAD_RIGHT, 32'd9999);
        repeat (4) send_request(sssd_pkg::CMD_TICK, 32'hffff_ffff);
        send_request(sssd_pkg::CMD_LOAD_ALL, 32'hffff_ffff);
        repeat (4) send_request(sssd_pkg::CMD_TICK, $urandom);
        send_request(sssd_pkg::CMD_LOAD_ALL, 32'd100_000_000);
        send_request(sssd_pkg::CMD_LOAD_RIGHT, 32'hffff_ffff);
        send_request(sssd_pkg::CMD_LOAD_LEFT, 32'd0);
        repeat (4) send_request(sssd_pkg::CMD_TICK, $urandom);
        send_request(sssd_pkg::CMD_LOAD_ALL, 32'd99_999_999);
        send_request(sssd_pkg::CMD_LOAD_RIGHT, 32'd0);
        drain();

        for (int p = 0; p < 4; p++)
        begin
            case (p)
                0:
                begin
                    idle_pct  = 0;
                    stall_pct = 0;
                end
                1:
                begin
                    idle_pct  = 62;
                    stall_pct = 0;
                end
                2:
                begin
                    idle_pct  = 0;
                    stall_pct = 62;
                end
                default:
                begin
                    idle_pct  = 33;
                    stall_pct = 33;
                end
            endcase
            if (p == 2)
            begin
                hold_phase = 1'b1;
                while (!hold_done)
                    send_request(sssd_pkg::CMD_TICK, $urandom);
            end
            while (ticks_sent + loads_sent < (p + 1) * PHASE_ITEMS)
            begin
                if ($urandom_range(9) < 7)
                begin
                    send_request(sssd_pkg::command_t'($urandom_range(1, 3)), pick_number());
                    repeat ($urandom_range(8, 12)) send_request(sssd_pkg::CMD_TICK, $urandom);
                end
                else
                    send_request(sssd_pkg::command_t'($urandom_range(3)), $urandom);
            end
            drain();
        end

        req.valid <= 1'b0;
        for (wait_cycles = 0; wait_cycles < 5000 && words_pending != 0; wait_cycles++)
            @(posedge clk);
        repeat (20) @(posedge clk);

        $display("Sent %0d ticks and %0d loads over four handshake mixes and a long hold-off;",
                 ticks_sent, loads_sent);
        $display("%0d scan words matched, with dash, eight-digit and edge-value loads mixed in.",
                 words_checked);
        if (mismatches == 0 && words_pending == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

[seven_segment_scan_driver.f]
hdl/sssd_pkg.sv
hdl/sssd_req_if.sv
hdl/sssd_res_if.sv
hdl/sssd_split.sv
hdl/sssd_digits.sv
hdl/sssd_scan.sv
hdl/seven_segment_scan_driver.sv
sim/sssd_checker.sv
sim/tb.sv
